[src/handheld_bus_decoder_io_masks_unit_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the handheld bus decoder
// Shared concurrent-check wrappers, clocked on clk with reset on rst_n.
// ----------------------------------------------------------------------------
`ifndef HANDHELD_BUS_DECODER_IO_MASKS_UNIT_ASSERT_SVH
`define HANDHELD_BUS_DECODER_IO_MASKS_UNIT_ASSERT_SVH

// Same-cycle implication.
`define HBD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define HBD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/hbd_pkg.sv]
// ----------------------------------------------------------------------------
// hbd_pkg
// Types, codes and map constants shared by the bus decoder modules.
// ----------------------------------------------------------------------------
package hbd_pkg;

  localparam int BOOT_STORE_DEPTH_DEF = 2048;
  localparam int BOOT_IDX_W           = 11;   // covers the default boot store depth
  localparam int CMDQ_DEPTH           = 2;
  localparam int RESQ_DEPTH           = 2;

  localparam logic [15:0] ECHO_FOLD     = 16'h2000;
  localparam logic [15:0] IO_BASE       = 16'hFF00;
  localparam logic [15:0] ROM_FIXED_END = 16'h3FFF;
  localparam logic [15:0] ROM_END       = 16'h7FFF;
  localparam logic [15:0] CRAM_BASE     = 16'hA000;
  localparam logic [15:0] CRAM_END      = 16'hBFFF;
  localparam logic [15:0] ECHO_BASE     = 16'hE000;
  localparam logic [15:0] ECHO_END      = 16'hFDFF;
  localparam logic [15:0] RSVD_BASE     = 16'hFEA0;
  localparam logic [15:0] RSVD_END      = 16'hFEFF;
  localparam logic [15:0] BOOT_LO_END   = 16'h00FF;
  localparam logic [15:0] BOOT_HI_BASE  = 16'h0200;
  localparam logic [15:0] BOOT_HI_END   = 16'h08FF;
  localparam logic [15:0] BOOT_HI_SHIFT = 16'h0100;
  localparam logic [15:0] BOOT_DIS_ADDR = 16'hFF50;  // boot-disable register
  localparam logic [8:0]  IO_PAGE       = 9'h1FE;  // address[15:7] of FF00-FF7F

  localparam logic [6:0] IO_DIV  = 7'h04;
  localparam logic [6:0] IO_TIMA = 7'h05;

  typedef enum logic [1:0] {
    CMD_READ      = 2'd0,
    CMD_WRITE     = 2'd1,
    CMD_CART_LOAD = 2'd2,
    CMD_BOOT_LOAD = 2'd3
  } cmd_t;

  localparam logic [2:0] CART_NONE    = 3'd0;
  localparam logic [2:0] CART_REG_WR  = 3'd1;
  localparam logic [2:0] CART_BANK_RD = 3'd2;
  localparam logic [2:0] CART_RAM_WR  = 3'd3;
  localparam logic [2:0] CART_RAM_RD  = 3'd4;

  localparam logic [1:0] TMR_NONE = 2'd0;
  localparam logic [1:0] TMR_DIV  = 2'd1;
  localparam logic [1:0] TMR_TIMA = 2'd2;

  localparam logic CFG_BOOT_SPLIT   = 1'b0;
  localparam logic CFG_CART_PRESENT = 1'b1;

  typedef enum logic [2:0] {
    OP_FIXED     = 3'd0,  // result known at decode, no storage touched
    OP_READ      = 3'd1,
    OP_ROM_READ  = 3'd2,  // fixed ROM read, boot overlay possible
    OP_WRITE     = 3'd3,
    OP_IO_WRITE  = 3'd4,  // read-modify-write with keep mask
    OP_BOOT_LOAD = 3'd5
  } op_kind_t;

  typedef struct packed {
    op_kind_t              kind;
    logic [15:0]           maddr;
    logic [7:0]            wdata;
    logic [7:0]            keep;
    logic [BOOT_IDX_W-1:0] boot_idx;
    logic                  boot_hit;
    logic                  boot_in;
    logic                  refused;
    logic [2:0]            cart_op;
    logic [1:0]            timer_event;
  } op_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       refused;
    logic [2:0] cart_op;
    logic [1:0] timer_event;
  } res_t;

  // Reset contents of an I/O register.
  function automatic logic [7:0] io_preset(input logic [6:0] reg_idx);
    logic [7:0] v;
    unique case (reg_idx)
      7'h00: v = 8'hCF;  7'h01: v = 8'h00;  7'h02: v = 8'h7E;  7'h04: v = 8'hAB;
      7'h05: v = 8'h00;  7'h06: v = 8'h00;  7'h07: v = 8'hF8;  7'h0F: v = 8'hE1;
      7'h10: v = 8'h80;  7'h11: v = 8'hBF;  7'h12: v = 8'hF3;  7'h13: v = 8'hFF;
      7'h14: v = 8'hBF;  7'h16: v = 8'h3F;  7'h17: v = 8'h00;  7'h18: v = 8'hFF;
      7'h19: v = 8'hBF;  7'h1A: v = 8'h7F;  7'h1B: v = 8'hFF;  7'h1C: v = 8'h9F;
      7'h1D: v = 8'hFF;  7'h1E: v = 8'hBF;  7'h20: v = 8'hFF;  7'h21: v = 8'h00;
      7'h22: v = 8'h00;  7'h23: v = 8'hBF;  7'h24: v = 8'h77;  7'h25: v = 8'hF3;
      7'h26: v = 8'hF1;  7'h40: v = 8'h91;  7'h41: v = 8'h85;  7'h42: v = 8'h00;
      7'h43: v = 8'h00;  7'h44: v = 8'h00;  7'h45: v = 8'h00;  7'h46: v = 8'hFF;
      7'h47: v = 8'hFC;  7'h4A: v = 8'h00;  7'h4B: v = 8'h00;
      default: v = 8'hFF;
    endcase
    return v;
  endfunction

  // Bits a write leaves untouched in an I/O register.
  function automatic logic [7:0] io_keep(input logic [6:0] reg_idx);
    logic [7:0] k;
    unique case (reg_idx)
      7'h00: k = 8'hCF;
      7'h02: k = 8'h7E;
      7'h07: k = 8'hF8;
      7'h0F: k = 8'hE0;
      7'h10: k = 8'h80;
      7'h14, 7'h19, 7'h1E: k = 8'h38;
      7'h1A: k = 8'h7F;
      7'h1C: k = 8'h9F;
      7'h20: k = 8'hC0;
      7'h23: k = 8'h3F;
      7'h26: k = 8'h7F;
      7'h41: k = 8'h80;
      7'h01, 7'h05, 7'h06, 7'h11, 7'h12, 7'h13, 7'h16, 7'h17, 7'h18, 7'h1B,
      7'h1D, 7'h21, 7'h22, 7'h24, 7'h25, 7'h40, 7'h42, 7'h43, 7'h45, 7'h46,
      7'h47, 7'h48, 7'h49, 7'h4A, 7'h4B: k = 8'h00;
      default: k = 8'hFF;  // LY, boot-disable, unmapped
    endcase
    return k;
  endfunction

  // Value written by the post-reset clearing pass.
  function automatic logic [7:0] clear_value(input logic [15:0] addr);
    logic [7:0] v;
    v = (addr[15:7] == IO_PAGE) ? io_preset(addr[6:0]) : 8'h00;
    return v;
  endfunction

endpackage

[src/handheld_bus_decoder_io_masks_unit.sv]
// Writes, loads, cartridge and refused cases are queued as results by the
//   state that pops them; reads and I/O writes first pass a registered main
//   memory read and the execute state, which takes no new request meanwhile.
// Throughput: one request per cycle for writes and loads while the result queue has room.
// Reset: synchronous, active low; a clearing pass then fills all 65536 main
//   memory bytes with zeros and I/O presets, with in_full held high meanwhile.
// ----------------------------------------------------------------------------
// handheld_bus_decoder_io_masks_unit
// Byte bus decoder for a handheld console memory map with I/O write masks.
// ----------------------------------------------------------------------------
module handheld_bus_decoder_io_masks_unit import hbd_pkg::*; #(
  parameter int BOOT_STORE_DEPTH = BOOT_STORE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // config write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic        cfg_data,
  // request side
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_cmd,
  input  logic [15:0] in_address,
  input  logic [7:0]  in_write_data,
  // result side
  output logic        out_empty,
  input  logic        out_pop,
  output logic [7:0]  out_read_data,
  output logic        out_refused,
  output logic [2:0]  out_cart_op,
  output logic [1:0]  out_timer_event
);

  op_t  dec_op, cq_op;
  logic cq_full, cq_empty, cq_pop;
  logic res_full, res_push;
  res_t res_in, res_out;
  logic clearing;

  // No requests taken while memory is being initialized.
  assign in_full = cq_full || clearing;

  // Front: config registers and region decode.
  hbd_front #(
    .BOOT_STORE_DEPTH(BOOT_STORE_DEPTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_cmd       (in_cmd),
    .in_address   (in_address),
    .in_write_data(in_write_data),
    .op_o         (dec_op)
  );

  // Decoded op queue: lets decode run ahead of execute.
  hbd_fifo #(
    .T    (op_t),
    .DEPTH(CMDQ_DEPTH)
  ) u_cmdq (
    .clk  (clk),
    .rst_n(rst_n),
    .push (in_push && !in_full),
    .din  (dec_op),
    .full (cq_full),
    .pop  (cq_pop),
    .dout (cq_op),
    .empty(cq_empty)
  );

  // Back: memories, read-modify-write, boot overlay.
  hbd_back #(
    .BOOT_STORE_DEPTH(BOOT_STORE_DEPTH)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cq_empty(cq_empty),
    .cq_op   (cq_op),
    .cq_pop  (cq_pop),
    .res_full(res_full),
    .res_push(res_push),
    .res_data(res_in),
    .clearing(clearing)
  );

  // Result queue: execute keeps going while the consumer stalls.
  hbd_fifo #(
    .T    (res_t),
    .DEPTH(RESQ_DEPTH)
  ) u_resq (
    .clk  (clk),
    .rst_n(rst_n),
    .push (res_push),
    .din  (res_in),
    .full (res_full),
    .pop  (out_pop),
    .dout (res_out),
    .empty(out_empty)
  );

  assign out_read_data   = res_out.read_data;
  assign out_refused     = res_out.refused;
  assign out_cart_op     = res_out.cart_op;
  assign out_timer_event = res_out.timer_event;

endmodule

[src/hbd_fifo.sv]
// ----------------------------------------------------------------------------
// hbd_fifo
// Small register queue used between decode and execute and on the result side.
// ----------------------------------------------------------------------------
module hbd_fifo #(
  parameter type T     = logic,
  parameter int  DEPTH = 2
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  T     din,
  output logic full,
  input  logic pop,
  output T     dout,
  output logic empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  T              store_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = store_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

[src/hbd_front.sv]
// ----------------------------------------------------------------------------
// hbd_front
// Config registers and address decode of one bus request into an op.
// ----------------------------------------------------------------------------
module hbd_front import hbd_pkg::*; #(
  parameter int BOOT_STORE_DEPTH = BOOT_STORE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic        cfg_data,
  input  logic [1:0]  in_cmd,
  input  logic [15:0] in_address,
  input  logic [7:0]  in_write_data,
  output op_t         op_o
);

  localparam logic [15:0]           DEPTH_A = 16'(BOOT_STORE_DEPTH);
  localparam logic [BOOT_IDX_W:0]   DEPTH_I = (BOOT_IDX_W + 1)'(BOOT_STORE_DEPTH);

  logic boot_split_r, cart_present_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      boot_split_r   <= 1'b0;
      cart_present_r <= 1'b0;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_BOOT_SPLIT) begin
        boot_split_r <= cfg_data;
      end
      if (cfg_index == CFG_CART_PRESENT) begin
        cart_present_r <= cfg_data;
      end
    end
  end

  always_comb begin
    logic [15:0]           a;
    logic [15:0]           hi_off;
    logic [BOOT_IDX_W-1:0] ridx;
    logic                  rhit;
    logic [6:0]            reg_idx;
    a       = in_address;
    hi_off  = a - BOOT_HI_SHIFT;
    reg_idx = a[6:0];
    rhit    = 1'b0;
    ridx    = a[BOOT_IDX_W-1:0];
    if (a <= BOOT_LO_END) begin
      rhit = 1'b1;
    end else if (boot_split_r && a >= BOOT_HI_BASE && a <= BOOT_HI_END) begin
      rhit = 1'b1;
      ridx = hi_off[BOOT_IDX_W-1:0];
    end

    op_o             = '0;
    op_o.kind        = OP_FIXED;
    op_o.maddr       = a;
    op_o.wdata       = in_write_data;
    op_o.keep        = 8'h00;
    op_o.boot_idx    = ridx;
    op_o.boot_hit    = rhit;
    op_o.boot_in     = ({1'b0, ridx} < DEPTH_I);
    op_o.refused     = 1'b0;
    op_o.cart_op     = CART_NONE;
    op_o.timer_event = TMR_NONE;

    unique case (cmd_t'(in_cmd))
      CMD_BOOT_LOAD: begin
        op_o.boot_idx = a[BOOT_IDX_W-1:0];
        if (a < DEPTH_A) begin
          op_o.kind = OP_BOOT_LOAD;
        end
      end
      CMD_READ: begin
        priority if (a <= ROM_FIXED_END) begin
          op_o.kind = OP_ROM_READ;
        end else if (a <= ROM_END) begin
          op_o.cart_op = CART_BANK_RD;
        end else if (a >= CRAM_BASE && a <= CRAM_END) begin
          op_o.cart_op = CART_RAM_RD;
        end else if (a >= ECHO_BASE && a <= ECHO_END) begin
          op_o.kind  = OP_READ;
          op_o.maddr = a - ECHO_FOLD;
        end else if (a >= RSVD_BASE && a <= RSVD_END) begin
          op_o.refused = 1'b1;
        end else begin
          op_o.kind = OP_READ;
        end
      end
      CMD_WRITE, CMD_CART_LOAD: begin
        priority if (a <= ROM_END) begin
          if (cmd_t'(in_cmd) == CMD_CART_LOAD) begin
            op_o.kind = OP_WRITE;
          end else if (cart_present_r) begin
            op_o.cart_op = CART_REG_WR;
          end else begin
            op_o.refused = 1'b1;
          end
        end else if (a >= CRAM_BASE && a <= CRAM_END) begin
          op_o.cart_op = CART_RAM_WR;
        end else if (a >= ECHO_BASE && a <= ECHO_END) begin
          op_o.kind  = OP_WRITE;
          op_o.maddr = a - ECHO_FOLD;
        end else if (a >= RSVD_BASE && a <= RSVD_END) begin
          op_o.refused = 1'b1;
        end else if (a[15:7] == IO_PAGE) begin
          op_o.kind = OP_IO_WRITE;
          if (reg_idx == IO_DIV) begin
            // divider write clears the register
            op_o.wdata       = 8'h00;
            op_o.timer_event = TMR_DIV;
          end else begin
            op_o.keep = io_keep(reg_idx);
            if (reg_idx == IO_TIMA) begin
              op_o.timer_event = TMR_TIMA;
            end
          end
        end else begin
          op_o.kind = OP_WRITE;
        end
      end
      default: op_o.kind = OP_FIXED;
    endcase
  end

endmodule

[src/hbd_back.sv]
// ----------------------------------------------------------------------------
// hbd_back
// Executes decoded ops against main memory and boot store; clears after reset.
// ----------------------------------------------------------------------------
module hbd_back import hbd_pkg::*; #(
  parameter int BOOT_STORE_DEPTH = BOOT_STORE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cq_empty,
  input  op_t  cq_op,
  output logic cq_pop,
  input  logic res_full,
  output logic res_push,
  output res_t res_data,
  output logic clearing
);

`include "handheld_bus_decoder_io_masks_unit_assert.svh"

  localparam int BW = $clog2(BOOT_STORE_DEPTH);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_t;

  state_t      state_r, state_nxt;
  logic [15:0] clr_addr_r, clr_addr_nxt;
  op_t         cur_r, cur_nxt;
  logic        ov_r, ov_nxt;  // boot overlay active (boot-disable reads zero)

  logic [7:0]  main_mem [65536];
  logic [7:0]  boot_mem [BOOT_STORE_DEPTH];
  logic [7:0]  mem_q_r, boot_q_r;

  logic        mem_we, boot_we;
  logic [15:0] mem_waddr;
  logic [7:0]  mem_wdata;

  assign clearing = (state_r == S_CLEAR);

  always_comb begin
    logic [7:0] io_val;
    io_val       = (cur_r.wdata & ~cur_r.keep) | (mem_q_r & cur_r.keep);
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    cur_nxt      = cur_r;
    ov_nxt       = ov_r;
    cq_pop       = 1'b0;
    res_push     = 1'b0;
    res_data     = '0;
    mem_we       = 1'b0;
    mem_waddr    = cur_r.maddr;
    mem_wdata    = 8'h00;
    boot_we      = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        mem_we       = 1'b1;
        mem_waddr    = clr_addr_r;
        mem_wdata    = clear_value(clr_addr_r);
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == 16'hFFFF) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (!cq_empty && !res_full) begin
          cq_pop               = 1'b1;
          cur_nxt              = cq_op;
          res_data.refused     = cq_op.refused;
          res_data.cart_op     = cq_op.cart_op;
          res_data.timer_event = cq_op.timer_event;
          unique case (cq_op.kind)
            OP_WRITE: begin
              mem_we             = 1'b1;
              mem_waddr          = cq_op.maddr;
              mem_wdata          = cq_op.wdata;
              res_push           = 1'b1;
              res_data.read_data = cq_op.wdata;
            end
            OP_BOOT_LOAD: begin
              boot_we            = 1'b1;
              ov_nxt             = 1'b1;
              // boot-disable register reads back zero from here on
              mem_we             = 1'b1;
              mem_waddr          = BOOT_DIS_ADDR;
              mem_wdata          = 8'h00;
              res_push           = 1'b1;
              res_data.read_data = cq_op.wdata;
            end
            OP_READ, OP_ROM_READ, OP_IO_WRITE: begin
              state_nxt = S_EXEC;  // wait for the registered read
            end
            default: begin
              res_push = 1'b1;
            end
          endcase
        end
      end
      S_EXEC: begin
        res_push             = 1'b1;
        res_data.refused     = cur_r.refused;
        res_data.cart_op     = cur_r.cart_op;
        res_data.timer_event = cur_r.timer_event;
        state_nxt            = S_IDLE;
        unique case (cur_r.kind)
          OP_ROM_READ: begin
            if (ov_r && cur_r.boot_hit) begin
              res_data.read_data = cur_r.boot_in ? boot_q_r : 8'h00;
            end else begin
              res_data.read_data = mem_q_r;
            end
          end
          OP_IO_WRITE: begin
            mem_we             = 1'b1;
            mem_wdata          = io_val;
            res_data.read_data = io_val;
          end
          default: begin
            res_data.read_data = mem_q_r;
          end
        endcase
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  // Storage: one write port, one registered read port each.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      main_mem[mem_waddr] <= mem_wdata;
    end
    mem_q_r <= main_mem[cq_op.maddr];
  end

  always_ff @(posedge clk) begin
    if (boot_we) begin
      boot_mem[cq_op.boot_idx[BW-1:0]] <= cq_op.wdata;
    end
    boot_q_r <= boot_mem[cq_op.boot_idx[BW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      clr_addr_r <= '0;
      ov_r       <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      ov_r       <= ov_nxt;
    end
    cur_r <= cur_nxt;
  end

  `HBD_ASSERT_NOW(a_clear_quiet, state_r == S_CLEAR, !res_push && !cq_pop, "activity during clear")
  `HBD_ASSERT_NEXT(a_exec_done, state_r == S_EXEC, state_r == S_IDLE, "exec did not finish")
  `HBD_ASSERT_NEXT(a_boot_ov, cq_pop && cq_op.kind == OP_BOOT_LOAD, ov_r, "overlay not enabled")
  `HBD_ASSERT_NEXT(a_ov_sticky, ov_r, ov_r, "overlay dropped")

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the handheld bus decoder: queued byte requests,
// an in-bench memory-map predictor, and field-by-field reply checks.
// ----------------------------------------------------------------------------
module tb_top import hbd_pkg::*;;

  localparam int BOOT_DEPTH  = BOOT_STORE_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 600_000;  // clearing pass + worst-case traffic, several times
  localparam int PHASE_ITEMS = 480;
  localparam int PRINT_CAP   = 40;

  localparam logic [15:0] VRAM_BASE      = 16'h8000;
  localparam logic [15:0] WRAM_BASE      = 16'hC000;
  localparam logic [15:0] OAM_BASE       = 16'hFE00;
  localparam logic [15:0] HRAM_BASE      = 16'hFF80;
  localparam logic [15:0] BOOT_CTRL_ADDR = 16'hFF50;  // boot-disable register

  // Power-on I/O values, {register, value} pairs.
  localparam logic [39*16-1:0] IO_POWER_ON = {
    16'h00CF, 16'h0100, 16'h027E, 16'h04AB, 16'h0500, 16'h0600, 16'h07F8, 16'h0FE1,
    16'h1080, 16'h11BF, 16'h12F3, 16'h13FF, 16'h14BF, 16'h163F, 16'h1700, 16'h18FF,
    16'h19BF, 16'h1A7F, 16'h1BFF, 16'h1C9F, 16'h1DFF, 16'h1EBF, 16'h20FF, 16'h2100,
    16'h2200, 16'h23BF, 16'h2477, 16'h25F3, 16'h26F1, 16'h4091, 16'h4185, 16'h4200,
    16'h4300, 16'h4400, 16'h4500, 16'h46FF, 16'h47FC, 16'h4A00, 16'h4B00};

  // Read-only bits per I/O register, {register, keep} pairs; unlisted keep all.
  localparam logic [39*16-1:0] IO_RO_BITS = {
    16'h00CF, 16'h027E, 16'h07F8, 16'h0FE0, 16'h1080, 16'h1438, 16'h1938, 16'h1E38,
    16'h1A7F, 16'h1C9F, 16'h20C0, 16'h233F, 16'h267F, 16'h4180, 16'h0100, 16'h0500,
    16'h0600, 16'h1100, 16'h1200, 16'h1300, 16'h1600, 16'h1700, 16'h1800, 16'h1B00,
    16'h1D00, 16'h2100, 16'h2200, 16'h2400, 16'h2500, 16'h4000, 16'h4200, 16'h4300,
    16'h4500, 16'h4600, 16'h4700, 16'h4800, 16'h4900, 16'h4A00, 16'h4B00};

  typedef enum logic [1:0] {
    STEP_ACCESS,
    STEP_CFG,
    STEP_PAUSE  // hold off until every reply is back
  } plan_kind_t;

  typedef enum logic [1:0] {
    POP_STEADY,
    POP_COIN,
    POP_STALLS
  } pop_style_t;

  typedef struct packed {
    plan_kind_t  kind;
    cmd_t        cmd;
    logic [15:0] addr;
    logic [7:0]  data;
    logic        cfg_idx;
    logic        cfg_val;
  } plan_step_t;

  // DUT connections
  logic        clk           = 1'b0;
  logic        rst_n         = 1'b0;
  logic        cfg_valid     = 1'b0;
  logic        cfg_ready;
  logic        cfg_index     = CFG_BOOT_SPLIT;
  logic        cfg_data      = 1'b0;
  logic        in_push       = 1'b0;
  logic        in_full;
  logic [1:0]  in_cmd        = CMD_READ;
  logic [15:0] in_address    = 16'h0000;
  logic [7:0]  in_write_data = 8'h00;
  logic        out_empty;
  logic        out_pop       = 1'b0;
  logic [7:0]  out_read_data;
  logic        out_refused;
  logic [2:0]  out_cart_op;
  logic [1:0]  out_timer_event;

  // Request plan and replies still owed by the DUT
  plan_step_t access_plan[$];
  res_t       replies_due[$];

  // Predictor state: memory image, boot image, config
  logic [7:0] main_image [0:65535];
  logic [7:0] boot_image [0:BOOT_DEPTH-1];
  logic [7:0] io_keep_tbl [0:127];
  logic       split_cfg = 1'b0;
  logic       cart_cfg  = 1'b0;

  // Plan-time shadow, so no read ever lands on an unloaded boot byte
  logic plan_split   = 1'b0;
  bit   plan_overlay = 1'b0;
  bit   plan_loaded [0:BOOT_DEPTH-1];
  int   planned_items = 0;

  // Traffic shaping
  int         burst_left = 0;
  int         gap_left   = 0;
  pop_style_t pop_style  = POP_STEADY;
  int         pop_left   = 0;
  int         stall_left = 0;

  // Bookkeeping
  int unsigned cycles          = 0;
  int          faults          = 0;
  int          replies_checked = 0;
  int          cfg_writes      = 0;
  int          n_requests      = 0;
  int          n_boot_loads    = 0;
  int          n_overlay_reads = 0;
  int          n_refused       = 0;
  int          n_cart          = 0;
  int          n_timer         = 0;

  handheld_bus_decoder_io_masks_unit #(
    .BOOT_STORE_DEPTH(BOOT_DEPTH)
  ) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_cmd         (in_cmd),
    .in_address     (in_address),
    .in_write_data  (in_write_data),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_read_data  (out_read_data),
    .out_refused    (out_refused),
    .out_cart_op    (out_cart_op),
    .out_timer_event(out_timer_event)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Boot image slot seen by a fixed-ROM read, -1 when outside the image.
  function automatic int boot_slot(input logic [15:0] a, input logic split);
    int slot;
    slot = -1;
    if (a <= BOOT_LO_END)
      slot = int'(a);
    else if (split && a >= BOOT_HI_BASE && a <= BOOT_HI_END)
      slot = int'(a - BOOT_HI_SHIFT);
    return slot;
  endfunction

  task automatic reset_memory_image();
    logic [15:0] e;
    for (int i = 0; i < 65536; i++) main_image[i] = 8'h00;
    for (int i = 0; i < BOOT_DEPTH; i++) boot_image[i] = 8'h00;
    for (int i = 0; i < 128; i++) begin
      main_image[IO_BASE + i] = 8'hFF;
      io_keep_tbl[i] = 8'hFF;
    end
    for (int i = 0; i < 39; i++) begin
      e = IO_POWER_ON[i*16 +: 16];
      main_image[IO_BASE + e[15:8]] = e[7:0];
      e = IO_RO_BITS[i*16 +: 16];
      io_keep_tbl[e[14:8]] = e[7:0];
    end
  endtask

  // Work out the reply for one accepted request and queue it.
  task automatic decode_bus_access(input cmd_t cmd, input logic [15:0] a,
                                   input logic [7:0] d);
    res_t       r;
    int         slot;
    logic [6:0] io_reg;
    logic [7:0] keep;
    logic [7:0] v;
    r = '0;
    n_requests++;
    if (cmd == CMD_BOOT_LOAD) begin
      // out-of-range index: dropped, overlay state untouched
      if (a < BOOT_DEPTH) begin
        boot_image[a] = d;
        main_image[BOOT_CTRL_ADDR] = 8'h00;
        r.read_data = d;
        n_boot_loads++;
      end
    end else if (cmd == CMD_READ) begin
      if (a <= ROM_FIXED_END) begin
        slot = boot_slot(a, split_cfg);
        if (main_image[BOOT_CTRL_ADDR] == 8'h00 && slot >= 0) begin
          r.read_data = (slot < BOOT_DEPTH) ? boot_image[slot] : 8'h00;
          n_overlay_reads++;
        end else begin
          r.read_data = main_image[a];
        end
      end else if (a <= ROM_END) begin
        r.cart_op = CART_BANK_RD;
      end else if (a >= CRAM_BASE && a <= CRAM_END) begin
        r.cart_op = CART_RAM_RD;
      end else if (a >= ECHO_BASE && a <= ECHO_END) begin
        r.read_data = main_image[a - ECHO_FOLD];
      end else if (a >= RSVD_BASE && a <= RSVD_END) begin
        r.refused = 1'b1;
      end else begin
        r.read_data = main_image[a];
      end
    end else begin
      // plain write or cartridge image load
      if (a <= ROM_END) begin
        if (cmd == CMD_CART_LOAD) begin
          main_image[a] = d;
          r.read_data = d;
        end else if (cart_cfg) begin
          r.cart_op = CART_REG_WR;
        end else begin
          r.refused = 1'b1;
        end
      end else if (a >= CRAM_BASE && a <= CRAM_END) begin
        r.cart_op = CART_RAM_WR;
      end else if (a >= ECHO_BASE && a <= ECHO_END) begin
        main_image[a - ECHO_FOLD] = d;
        r.read_data = d;
      end else if (a >= RSVD_BASE && a <= RSVD_END) begin
        r.refused = 1'b1;
      end else if (a[15:7] == IO_PAGE) begin
        io_reg = a[6:0];
        if (io_reg == IO_DIV) begin
          // any write clears the divider
          v = 8'h00;
          r.timer_event = TMR_DIV;
        end else begin
          keep = io_keep_tbl[io_reg];
          v = (d & ~keep) | (main_image[a] & keep);
          if (io_reg == IO_TIMA) r.timer_event = TMR_TIMA;
        end
        main_image[a] = v;
        r.read_data = v;
      end else begin
        main_image[a] = d;
        r.read_data = d;
      end
    end
    if (r.refused) n_refused++;
    if (r.cart_op != CART_NONE) n_cart++;
    if (r.timer_event != TMR_NONE) n_timer++;
    replies_due.push_back(r);
  endtask

  task automatic report_fault(input string what, input logic [31:0] got,
                              input logic [31:0] want);
    faults++;
    if (faults <= PRINT_CAP)
      $display("[%0t] reply %0d: bad %s, got 0x%0h, expected 0x%0h",
               $realtime, replies_checked, what, got, want);
  endtask

  // --------------------------------------------------------------------------
  // Plan building
  // --------------------------------------------------------------------------

  task automatic push_access(input cmd_t cmd, input logic [15:0] a,
                             input logic [7:0] d);
    plan_step_t s;
    s = '0;
    s.kind = STEP_ACCESS;
    s.cmd  = cmd;
    s.addr = a;
    s.data = d;
    access_plan.push_back(s);
    planned_items++;
    if (cmd == CMD_BOOT_LOAD && a < BOOT_DEPTH) begin
      plan_loaded[a] = 1'b1;
      plan_overlay = 1'b1;
    end
  endtask

  // Queue a request; an overlay read of a boot byte never loaded gets a
  // load of that byte placed ahead of it.
  task automatic plan_access(input cmd_t cmd, input logic [15:0] a,
                             input logic [7:0] d);
    int slot;
    slot = boot_slot(a, plan_split);
    if (cmd == CMD_READ && a <= ROM_FIXED_END && plan_overlay && slot >= 0 &&
        !plan_loaded[slot])
      push_access(CMD_BOOT_LOAD, slot[15:0], 8'($urandom_range(0, 255)));
    push_access(cmd, a, d);
  endtask

  task automatic plan_pause();
    plan_step_t s;
    s = '0;
    s.kind = STEP_PAUSE;
    access_plan.push_back(s);
  endtask

  // Registers change only with the DUT quiet, hence the leading pause.
  task automatic plan_setup(input logic split, input logic cart);
    plan_step_t s;
    plan_pause();
    s = '0;
    s.kind    = STEP_CFG;
    s.cfg_idx = CFG_BOOT_SPLIT;
    s.cfg_val = split;
    access_plan.push_back(s);
    s.cfg_idx = CFG_CART_PRESENT;
    s.cfg_val = cart;
    access_plan.push_back(s);
    plan_split = split;
  endtask

  // Region-weighted address; small windows so reads find earlier writes.
  function automatic logic [15:0] pick_address();
    int unsigned pick;
    logic [15:0] near;
    bit          hot;
    pick = $urandom_range(0, 99);
    near = 16'($urandom_range(0, 31));
    hot  = 1'($urandom_range(0, 1));
    if (pick < 8)  return 16'($urandom_range(0, 16'hFFFF));
    if (pick < 20) return ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, ROM_FIXED_END))
                                                      : 16'($urandom_range(0, BOOT_HI_END + 16'h100));
    if (pick < 27) return 16'($urandom_range(ROM_FIXED_END + 1, ROM_END));
    if (pick < 33) return hot ? VRAM_BASE + near : 16'($urandom_range(VRAM_BASE, CRAM_BASE - 1));
    if (pick < 39) return 16'($urandom_range(CRAM_BASE, CRAM_END));
    if (pick < 51) return hot ? WRAM_BASE + near : 16'($urandom_range(WRAM_BASE, ECHO_BASE - 1));
    if (pick < 61) return hot ? ECHO_BASE + near : 16'($urandom_range(ECHO_BASE, ECHO_END));
    if (pick < 67) return 16'($urandom_range(OAM_BASE, RSVD_BASE - 1));
    if (pick < 72) return 16'($urandom_range(RSVD_BASE, RSVD_END));
    if (pick < 92) return 16'(IO_BASE + (($urandom_range(0, 3) == 0) ? $urandom_range(0, 16'h7F)
                                                                     : $urandom_range(0, 16'h4F)));
    return 16'($urandom_range(HRAM_BASE, 16'hFFFF));
  endfunction

  task automatic plan_random_access();
    int unsigned pick;
    cmd_t        cmd;
    logic [15:0] a;
    pick = $urandom_range(0, 99);
    cmd  = (pick < 40) ? CMD_READ : (pick < 78) ? CMD_WRITE :
           (pick < 88) ? CMD_CART_LOAD : CMD_BOOT_LOAD;
    if (cmd == CMD_BOOT_LOAD) begin
      // mostly in range, some past the store to hit the drop path
      pick = $urandom_range(0, 19);
      a = (pick < 9)  ? 16'($urandom_range(0, 16'h00FF)) :
          (pick < 17) ? 16'($urandom_range(16'h0100, BOOT_DEPTH - 1)) :
                        16'($urandom_range(0, 16'hFFFF));
    end else begin
      a = pick_address();
    end
    plan_access(cmd, a, 8'($urandom_range(0, 255)));
  endtask

  // --------------------------------------------------------------------------
  // Driver: requests and config writes from the plan, in bursts with gaps
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    plan_step_t head;
    logic       push_nx;
    logic       cfg_nx;
    push_nx = in_push;
    cfg_nx  = cfg_valid;
    if (rst_n) begin
      if (in_push && !in_full) begin
        decode_bus_access(cmd_t'(in_cmd), in_address, in_write_data);
        head = access_plan.pop_front();
        push_nx = 1'b0;
        if (burst_left > 0) burst_left--;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_BOOT_SPLIT) split_cfg = cfg_data;
        else cart_cfg = cfg_data;
        cfg_writes++;
        head = access_plan.pop_front();
        cfg_nx = 1'b0;
      end
      if (!push_nx && !cfg_nx && access_plan.size() != 0) begin
        head = access_plan[0];
        case (head.kind)
          STEP_PAUSE: begin
            if (replies_due.size() == 0) head = access_plan.pop_front();
          end
          STEP_CFG: begin
            if (replies_due.size() == 0) begin
              cfg_nx = 1'b1;
              cfg_index <= head.cfg_idx;
              cfg_data <= head.cfg_val;
            end
          end
          default: begin
            if (burst_left == 0) begin
              burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                       : $urandom_range(1, 48);
              gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            end
            if (gap_left > 0) begin
              gap_left--;
            end else begin
              push_nx = 1'b1;
              in_cmd <= head.cmd;
              in_address <= head.addr;
              in_write_data <= head.data;
            end
          end
        endcase
      end
    end
    in_push <= push_nx;
    cfg_valid <= cfg_nx;
  end

  // --------------------------------------------------------------------------
  // Monitor: check each popped reply, pop with a changing stall style
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    res_t got;
    res_t want;
    logic pop_nx;
    if (rst_n && out_pop && !out_empty) begin
      got = {out_read_data, out_refused, out_cart_op, out_timer_event};
      replies_checked++;
      if (replies_due.size() == 0) begin
        report_fault("reply with none due", 32'(got), 32'd0);
      end else begin
        want = replies_due.pop_front();
        if (got.read_data !== want.read_data)
          report_fault("read_data", 32'(got.read_data), 32'(want.read_data));
        if (got.refused !== want.refused)
          report_fault("refused", 32'(got.refused), 32'(want.refused));
        if (got.cart_op !== want.cart_op)
          report_fault("cart_op", 32'(got.cart_op), 32'(want.cart_op));
        if (got.timer_event !== want.timer_event)
          report_fault("timer_event", 32'(got.timer_event), 32'(want.timer_event));
      end
    end
    if (pop_left == 0) begin
      pop_style = pop_style_t'($urandom_range(0, 2));
      pop_left  = $urandom_range(40, 300);
    end
    pop_left--;
    case (pop_style)
      POP_STEADY: pop_nx = 1'b1;
      POP_COIN:   pop_nx = 1'($urandom_range(0, 1));
      default: begin
        if (stall_left > 0) begin
          stall_left--;
          pop_nx = 1'b0;
        end else begin
          pop_nx = 1'b1;
          if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 8);
        end
      end
    endcase
    out_pop <= pop_nx;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("handheld_bus_decoder_io_masks_unit: mismatch");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus plan, reset, end of run
  // --------------------------------------------------------------------------
  initial begin
    int         first;
    bit         paused;
    logic [3:0] split_seq;
    logic [3:0] cart_seq;
    split_seq = 4'b0101;  // bit p drives random phase p
    cart_seq  = 4'b0011;
    reset_memory_image();

    // Directed: boot image off, no cartridge
    plan_setup(1'b0, 1'b0);
    plan_access(CMD_READ,      16'h0000,      8'h00);  // fixed ROM, no overlay yet
    plan_access(CMD_WRITE,     16'h0000,      8'hFF);  // ROM write, no cartridge
    plan_access(CMD_CART_LOAD, ROM_FIXED_END, 8'hA5);
    plan_access(CMD_READ,      ROM_FIXED_END, 8'h00);
    plan_access(CMD_CART_LOAD, ROM_END,       8'h5A);
    plan_access(CMD_READ,      16'h4000,      8'h00);  // bank read to the port
    plan_access(CMD_WRITE,     CRAM_BASE,     8'h00);
    plan_access(CMD_READ,      CRAM_END,      8'h00);
    plan_access(CMD_WRITE,     ECHO_BASE,     8'h3C);  // echo folds onto work RAM
    plan_access(CMD_READ,      WRAM_BASE,     8'h00);
    plan_access(CMD_READ,      ECHO_END,      8'h00);
    plan_access(CMD_WRITE,     RSVD_BASE,     8'hFF);
    plan_access(CMD_READ,      RSVD_END,      8'h00);
    plan_access(CMD_WRITE,     RSVD_BASE - 1, 8'h81);  // last sprite byte
    plan_access(CMD_WRITE,     IO_BASE + IO_DIV,  8'hFF);
    plan_access(CMD_WRITE,     IO_BASE + IO_TIMA, 8'h80);
    plan_access(CMD_WRITE,     IO_BASE,       8'h30);  // joypad, masked bits
    plan_access(CMD_WRITE,     16'hFF44,      8'h00);  // LY keeps its value
    plan_access(CMD_WRITE,     BOOT_CTRL_ADDR, 8'h00); // boot-disable keeps its value
    plan_access(CMD_WRITE,     16'hFFFF,      8'hFF);
    plan_access(CMD_READ,      16'hFFFF,      8'h00);
    plan_access(CMD_BOOT_LOAD, 16'hFFFF,      8'h77);  // past the store: dropped
    plan_access(CMD_BOOT_LOAD, 16'h0000,      8'h31);  // overlay turns on
    plan_access(CMD_READ,      16'h0000,      8'h00);
    plan_access(CMD_READ,      BOOT_CTRL_ADDR, 8'h00); // boot-disable now reads zero

    // Random phases, each under its own register setting
    for (int p = 0; p < 4; p++) begin
      plan_setup(split_seq[p], cart_seq[p]);
      if (p == 0) begin
        plan_access(CMD_BOOT_LOAD, 16'(BOOT_DEPTH - 1), 8'hEE);
        plan_access(CMD_READ,      BOOT_HI_END,    8'h00);  // split image upper end
        plan_access(CMD_WRITE,     16'h2000,       8'h01);  // cartridge register write
      end
      first  = planned_items;
      paused = 1'b0;
      while (planned_items - first < PHASE_ITEMS) begin
        if (!paused && planned_items - first >= PHASE_ITEMS / 2) begin
          plan_pause();
          paused = 1'b1;
        end
        plan_random_access();
      end
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (access_plan.size() != 0 || replies_due.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (replies_due.size() != 0)
      report_fault("replies never came", 32'(replies_due.size()), 32'd0);

    $display("run covered %0d requests (%0d boot loads, %0d boot image reads, %0d refused)",
             n_requests, n_boot_loads, n_overlay_reads, n_refused);
    $display("  %0d cartridge port ops, %0d timer strobes, %0d config writes, %0d replies",
             n_cart, n_timer, cfg_writes, replies_checked);
    if (faults == 0)
      $display("handheld_bus_decoder_io_masks_unit: match");
    else
      $display("handheld_bus_decoder_io_masks_unit: mismatch");
    $finish;
  end

endmodule
